/* hdl/mersenne_twister_generator_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the MT19937 generator
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_GENERATOR_ASSERT_SVH
`define MERSENNE_TWISTER_GENERATOR_ASSERT_SVH

// condition holds at every edge
`define MTG_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("mersenne_twister_generator: invariant violated");

// condition at one edge implies the consequent at the next edge
`define MTG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mersenne_twister_generator: sequence violated");

`endif

/* hdl/mtg_pkg.sv */
// ---------------------------------------------------------------------------
// mtg_pkg
// Constants, types and word functions of the MT19937 generator.
// ---------------------------------------------------------------------------
package mtg_pkg;

    localparam int          STATE_WORDS_DEF = 624;
    localparam int          SHIFT_OFFSET    = 397;
    localparam logic [31:0] DEFAULT_SEED    = 32'd5489;
    localparam logic [31:0] SEED_MULT       = 32'd1812433253;
    localparam int          SEED_SHIFT      = 30;
    localparam logic [31:0] TWIST_MATRIX    = 32'h9908b0df;
    localparam logic [31:0] TEMPER_MASK_B   = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_MASK_C   = 32'hefc60000;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_IDLE,
        ST_TWIST,
        ST_TWREAD
    } mtg_state_t;

    typedef enum logic {
        MODE_SEED = 1'b0,
        MODE_GEN  = 1'b1
    } mtg_mode_t;

    typedef struct packed {
        logic we;
        logic re_a;
        logic re_b;
    } mtg_mem_ctl_t;

    function automatic logic [31:0] mtg_temper(input logic [31:0] w);
        logic [31:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_MASK_B);
        y = y ^ ((y << 15) & TEMPER_MASK_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [31:0] mtg_twist(input logic [31:0] cur,
                                              input logic [31:0] nxt,
                                              input logic [31:0] far);
        logic [31:0] y;
        y = {cur[31], nxt[30:0]};
        return far ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'd0);
    endfunction

endpackage

/* hdl/mtg_store.sv */
// ---------------------------------------------------------------------------
// mtg_store
// State word memory: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module mtg_store
    import mtg_pkg::*;
#(
    parameter int  DEPTH = STATE_WORDS_DEF,
    localparam int AW    = $clog2(DEPTH)
)
(
    input  logic         clk,
    input  mtg_mem_ctl_t ctl,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]  wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [31:0]  rdata_a,
    output logic [31:0]  rdata_b
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (ctl.re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* hdl/mersenne_twister_generator.sv */
// ---------------------------------------------------------------------------
// mersenne_twister_generator
// MT19937 32-bit generator: seed fill, in-place twist and tempered output.
// ---------------------------------------------------------------------------
// Channel   Handshake          Ports
// input     start & !busy      mode, seed_value
// result    word_valid strobe  random_word
//
// Reset runs the seed fill from the default seed; busy stays high meanwhile.
// A seed word keeps busy high while it refills the store and returns nothing.
// A generate word with fresh state is read from the memory, then its tempered
// result is registered; one is taken each cycle while unused words remain, set
// by the memory read port. A generate word on a spent store twists first: busy
// stays high through the rewrite, one element per cycle through the memory, and
// word 0 is then read and tempered, its result following after busy falls.
// The receiver cannot stall; word_valid lasts one cycle.
// ---------------------------------------------------------------------------
`include "mersenne_twister_generator_assert.svh"

module mersenne_twister_generator
    import mtg_pkg::*;
#(
    parameter int STATE_WORDS = STATE_WORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [31:0] seed_value,
    output logic [31:0] random_word,
    output logic        word_valid
);

    localparam int            AW        = $clog2(STATE_WORDS);
    localparam int            CW        = $clog2(STATE_WORDS + 1);
    localparam logic [CW-1:0] LAST_K    = CW'(STATE_WORDS - 1);
    localparam logic [CW-1:0] END_K     = CW'(STATE_WORDS);
    localparam logic [AW-1:0] FAR_START = AW'(SHIFT_OFFSET);
    localparam logic [AW-1:0] FAR_LAST  = AW'(STATE_WORDS - 1);

    mtg_state_t    state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] far_reg, far_next;
    logic [31:0]   fill_word_reg, fill_word_next;
    logic          gen_pend_reg, gen_pend_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0] cmp_k_reg, cmp_k_next;
    logic          word_valid_reg;
    logic [31:0]   random_word_reg;
    logic [31:0]   hold_reg;

    mtg_mem_ctl_t  ctl;
    logic [AW-1:0] waddr, raddr_a, raddr_b;
    logic [31:0]   wdata, rdata_a, rdata_b;

    logic          accept, gen_direct;
    logic [31:0]   fill_mix, fill_prod, fill_calc;
    logic [CW-1:0] cnt_p1, cnt_m1;

    assign accept     = start && (state_reg == ST_IDLE);
    assign gen_direct = accept && (mode == MODE_GEN) && (idx_reg < END_K);

    assign cnt_p1    = cnt_reg + CW'(1);
    assign cnt_m1    = cnt_reg - CW'(1);
    assign fill_mix  = fill_word_reg ^ (fill_word_reg >> SEED_SHIFT);
    assign fill_prod = SEED_MULT * fill_mix;
    assign fill_calc = fill_prod + 32'(cnt_p1);

    mtg_store #(
        .DEPTH (STATE_WORDS)
    ) u_store (
        .clk     (clk),
        .ctl     (ctl),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (cnt_reg == LAST_K)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_SEED)
                    begin
                        state_next = ST_FILL;
                    end
                    else if (idx_reg >= END_K)
                    begin
                        state_next = ST_TWIST;
                    end
                end
            end
            ST_TWIST:
            begin
                if (cnt_reg == END_K)
                begin
                    state_next = ST_TWREAD;
                end
            end
            ST_TWREAD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_comb
    begin
        busy     = (state_reg != ST_IDLE);
        ctl.we   = (state_reg == ST_FILL) || cmp_valid_reg;
        ctl.re_a = 1'b0;
        ctl.re_b = 1'b0;
        waddr    = (state_reg == ST_FILL) ? cnt_reg[AW-1:0] : cmp_k_reg;
        wdata    = (state_reg == ST_FILL) ? fill_word_reg
                                          : mtg_twist(hold_reg, rdata_a, rdata_b);
        raddr_a  = '0;
        raddr_b  = far_reg;
        case (state_reg)
            ST_IDLE:
            begin
                ctl.re_a = gen_direct;
                raddr_a  = idx_reg[AW-1:0];
            end
            ST_TWIST:
            begin
                ctl.re_a = 1'b1;
                ctl.re_b = (cnt_reg != '0);
                raddr_a  = (cnt_reg == END_K) ? '0 : cnt_reg[AW-1:0];
            end
            ST_TWREAD:
            begin
                ctl.re_a = 1'b1;
            end
            default:
            begin
                ctl.re_a = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        far_next       = far_reg;
        fill_word_next = fill_word_reg;
        gen_pend_next  = gen_direct || (state_reg == ST_TWREAD);
        cmp_valid_next = (state_reg == ST_TWIST) && (cnt_reg != '0);
        cmp_k_next     = cnt_m1[AW-1:0];
        case (state_reg)
            ST_FILL:
            begin
                cnt_next       = cnt_p1;
                fill_word_next = fill_calc;
                if (cnt_reg == LAST_K)
                begin
                    idx_next = END_K;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_SEED)
                    begin
                        fill_word_next = seed_value;
                        cnt_next       = '0;
                    end
                    else if (idx_reg < END_K)
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                    else
                    begin
                        cnt_next = '0;
                        far_next = FAR_START;
                    end
                end
            end
            ST_TWIST:
            begin
                if (cnt_reg != END_K)
                begin
                    cnt_next = cnt_p1;
                end
                if (cnt_reg != '0)
                begin
                    far_next = (far_reg == FAR_LAST) ? '0 : far_reg + AW'(1);
                end
            end
            ST_TWREAD:
            begin
                idx_next = CW'(1);
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_FILL;
            idx_reg        <= END_K;
            cnt_reg        <= '0;
            far_reg        <= FAR_START;
            fill_word_reg  <= DEFAULT_SEED;
            gen_pend_reg   <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            far_reg        <= far_next;
            fill_word_reg  <= fill_word_next;
            gen_pend_reg   <= gen_pend_next;
            cmp_valid_reg  <= cmp_valid_next;
            word_valid_reg <= gen_pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_k_reg <= cmp_k_next;
        if (state_reg == ST_TWIST)
        begin
            hold_reg <= rdata_a;
        end
        if (gen_pend_reg)
        begin
            random_word_reg <= mtg_temper(rdata_a);
        end
    end

    assign random_word = random_word_reg;
    assign word_valid  = word_valid_reg;

    `MTG_ASSERT(a_idle_no_write, !((state_reg == ST_IDLE) && ctl.we))
    `MTG_ASSERT(a_index_range, idx_reg <= END_K)
    `MTG_ASSERT(a_no_rw_clash, !(ctl.we && ctl.re_b && (waddr == raddr_b)))
    `MTG_ASSERT_NEXT(a_fill_exit, (state_reg == ST_FILL) && (cnt_reg == LAST_K),
        (state_reg == ST_IDLE) && (idx_reg == END_K))
    `MTG_ASSERT_NEXT(a_twist_exit, state_reg == ST_TWREAD,
        gen_pend_reg && (state_reg == ST_IDLE) && (idx_reg == CW'(1)))

endmodule
